// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define CE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/ce_pkg.sv =====
// shared types and constants of the combination enumerator
package ce_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 4'd1;

  // broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic prep;     // capture pivot flags this cycle
    logic fire;     // the token cell updates and hands the token on
    logic restart;  // first combination: cells load their own index
    logic seen;     // pivot already passed, refill from the left neighbor
  } ce_ctl_t;

endpackage

// ===== rtl/combination_enumerator.sv =====
// combination enumerator: row of position cells walked by an emission token
//
//  channel  | direction | handshake                   | contents
//  ---------+-----------+-----------------------------+--------------------------------
//  s_axis   | in        | s_axis_tvalid_i/tready_o    | tdata[0] restart
//  m_axis   | out       | m_axis_tvalid_o/tready_i    | tdata element,position; tlast; tuser
//  cfg      | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
//  a request is accepted in ST_IDLE, the pivot is found in the cell row in ST_PREP,
//  then ST_EMIT gives out the positions one by one while the token walks the row
//  left to right; an exhausted request reaches ST_EXH from ST_IDLE or from ST_PREP
//  back pressure on m_axis holds the token in place; one result sits in the output
//  register while the block is free again after the last position is loaded
//  reset clears the control state only; cell values are loaded before first use
//  cfg is always ready; write it only while the block is idle, which it does not enforce
module combination_enumerator import ce_pkg::*; #(
  parameter int MAX_SET  = 64,
  parameter int MAX_PICK = 16,
  localparam int SW  = $clog2(MAX_SET),
  localparam int NW  = $clog2(MAX_SET + 1),
  localparam int PW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1,
  localparam int MW  = $clog2(MAX_PICK + 1),
  localparam int DW  = (NW > MW) ? NW : MW,
  localparam int OW  = ((SW + PW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [0] restart, rest zero
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OW-1:0]        m_axis_tdata_o,   // element, position, zero fill
  output logic                 m_axis_tlast_o,
  output logic                 m_axis_tuser_o,   // [0] exhausted
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DW-1:0]        cfg_data_i
);

  localparam int CW = DW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT,
    ST_EXH
  } state_e;

  state_e        state_q;
  logic [NW-1:0] set_size_q;
  logic [MW-1:0] pick_q;
  logic          started_q;
  logic          finished_q;
  logic          restart_q;   // current request loads the first combination
  logic          seen_q;      // pivot has been emitted in this request
  logic [PW-1:0] pos_q;

  logic          out_valid_q;
  logic [OW-1:0] out_data_q;
  logic          out_last_q;
  logic          out_exh_q;

  // cell row wiring
  logic [SW-1:0]     val  [MAX_PICK];
  logic [SW-1:0]     nval [MAX_PICK];
  logic [SW-1:0]     prev [MAX_PICK];
  logic [MAX_PICK-1:0] tok;
  logic [MAX_PICK-1:0] tok_in;
  logic [MAX_PICK-1:0] piv;
  logic [MAX_PICK-1:0] act;
  logic [MAX_PICK:0]   top_chain;   // cell k and all cells to its right sit at their ceiling

  ce_ctl_t       ctl;
  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          fire;
  logic          cfg_bad;
  logic          no_pivot;
  logic          load;
  logic          is_last;
  logic [CW-1:0] span;
  logic [SW-1:0] emit_elem;
  logic          emit_piv;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign fire     = (state_q == ST_EMIT) && out_free;
  // a new result enters the output register this cycle
  assign out_load = fire || ((state_q == ST_EXH) && out_free);
  assign no_pivot = top_chain[0];
  assign load     = (state_q == ST_PREP) && (restart_q || !no_pivot);
  assign is_last  = (pos_q == PW'(pick_q - MW'(1)));

  assign cfg_bad = (pick_q == '0) || (set_size_q == '0) ||
                   (CW'(pick_q) > CW'(set_size_q)) ||
                   (set_size_q > NW'(MAX_SET)) || (pick_q > MW'(MAX_PICK));

  // only meaningful for a valid configuration, where m <= n
  assign span = CW'(set_size_q) - CW'(pick_q);

  assign ctl.prep    = (state_q == ST_PREP);
  assign ctl.fire    = fire;
  assign ctl.restart = restart_q;
  assign ctl.seen    = seen_q;

  assign top_chain[MAX_PICK] = 1'b1;

  for (genvar k = 0; k < MAX_PICK; k++) begin : g_cell
    assign act[k] = (MW'(k) < pick_q);
    if (k == 0) begin : g_head
      assign tok_in[k] = load;
      assign prev[k]   = '0;
    end else begin : g_body
      assign tok_in[k] = tok[k-1] & fire;
      assign prev[k]   = val[k-1];
    end

    ce_cell #(
      .IDX (k),
      .SW  (SW),
      .CW  (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .act_i  (act[k]),
      .span_i (span),
      .top_i  (top_chain[k+1]),
      .top_o  (top_chain[k]),
      .tok_i  (tok_in[k]),
      .tok_o  (tok[k]),
      .prev_i (prev[k]),
      .val_o  (val[k]),
      .new_o  (nval[k]),
      .piv_o  (piv[k])
    );
  end

  // pick the updated value of the token cell
  always_comb begin
    emit_elem = '0;
    emit_piv  = 1'b0;
    for (int k = 0; k < MAX_PICK; k++) begin
      emit_elem = emit_elem | (nval[k] & {SW{tok[k]}});
      emit_piv  = emit_piv | (piv[k] & tok[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      set_size_q  <= '0;
      pick_q      <= '0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      restart_q   <= 1'b0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_exh_q   <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready_i);

      // register writes; any other index is dropped
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SET_SIZE: begin
            set_size_q <= cfg_data_i[NW-1:0];
            started_q  <= 1'b0;
            finished_q <= 1'b0;
          end
          REG_PICK_COUNT: begin
            pick_q     <= cfg_data_i[MW-1:0];
            started_q  <= 1'b0;
            finished_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (cfg_bad) begin
              state_q <= ST_EXH;
            end else if (s_axis_tdata_i[0] || !started_q) begin
              restart_q  <= 1'b1;
              started_q  <= 1'b1;
              finished_q <= 1'b0;
              state_q    <= ST_PREP;
            end else if (finished_q) begin
              state_q <= ST_EXH;
            end else begin
              restart_q <= 1'b0;
              state_q   <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          seen_q <= 1'b0;
          pos_q  <= '0;
          if (!restart_q && no_pivot) begin
            finished_q <= 1'b1;
            state_q    <= ST_EXH;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (fire) begin
            out_data_q  <= OW'({pos_q, emit_elem});
            out_last_q  <= is_last;
            out_exh_q   <= 1'b0;
            seen_q      <= seen_q | emit_piv;
            pos_q       <= pos_q + PW'(1);
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_EXH: begin
          if (out_free) begin
            out_data_q  <= '0;
            out_last_q  <= 1'b1;
            out_exh_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_exh_q;
  assign cfg_ready_o     = 1'b1;

endmodule

// ===== rtl/ce_cell.sv =====
// one position of the combination: value, pivot flag and token
module ce_cell import ce_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 6,
  parameter int CW  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ce_ctl_t       ctl_i,
  input  logic          act_i,
  input  logic [CW-1:0] span_i,
  input  logic          top_i,
  output logic          top_o,
  input  logic          tok_i,
  output logic          tok_o,
  input  logic [SW-1:0] prev_i,
  output logic [SW-1:0] val_o,
  output logic [SW-1:0] new_o,
  output logic          piv_o
);

  logic [SW-1:0] val_q;
  logic          tok_q, tok_d;
  logic          piv_q, piv_d;
  logic          at_top;
  logic          piv_now;
  logic [CW-1:0] ceil_val;

  // ceiling of this position is IDX + (n - m)
  assign ceil_val = CW'(IDX) + span_i;
  assign at_top   = !act_i || !(CW'(val_q) < ceil_val);
  assign top_o    = top_i & at_top;
  assign piv_now  = act_i & !at_top & top_i;

  always_comb begin
    if (ctl_i.restart) begin
      new_o = SW'(IDX);
    end else if (piv_q) begin
      new_o = val_q + SW'(1);
    end else if (ctl_i.seen) begin
      new_o = prev_i + SW'(1);
    end else begin
      new_o = val_q;
    end
  end

  assign tok_d = (tok_q & !ctl_i.fire) | (tok_i & act_i);
  assign piv_d = ctl_i.prep ? (piv_now & !ctl_i.restart) : piv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      piv_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      piv_q <= piv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire && tok_q) begin
      val_q <= new_o;
    end
  end

  assign tok_o = tok_q;
  assign val_o = val_q;
  assign piv_o = piv_q;

endmodule

// ===== rtl/ce_checker.sv =====
// port-level checks of the combination enumerator and their bind
`include "assert_macros.svh"

module ce_port_checker #(
  parameter int OW = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tready_o,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [OW-1:0] m_axis_tdata_o,
  input logic          m_axis_tlast_o,
  input logic          m_axis_tuser_o
);

  // an exhausted result always closes its request
  `CE_ASSERT_IMP(a_exh_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)

  // an exhausted result carries element 0 at position 0
  `CE_ASSERT_IMP(a_exh_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)

  // no new request is taken while a combination is still being given out
  `CE_ASSERT_IMP(a_busy_mid, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o)

  // a stalled result stays offered
  `CE_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

endmodule

bind combination_enumerator ce_port_checker #(
  .OW (OW)
) u_ce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/sv/ce_checker.sv =====
// checker of the combination enumerator: follows every channel, predicts results, compares
module ce_checker import ce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,
  input  logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  input  logic [15:0]          m_axis_tdata_o,
  input  logic                 m_axis_tlast_o,
  input  logic                 m_axis_tuser_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int SET_LIMIT  = 64;
  localparam int PICK_LIMIT = 16;

  typedef struct packed {
    logic [5:0] element;
    logic [3:0] position;
    logic       last;
    logic       exhausted;
  } combo_beat_t;

  combo_beat_t beat_q[$];
  logic [6:0]  set_size_q;
  logic [4:0]  pick_q;
  int          choice[PICK_LIMIT];
  bit          started;
  bit          finished;
  int          fails;
  int          pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void push_exhausted();
    combo_beat_t b;
    b.element   = '0;
    b.position  = '0;
    b.last      = 1'b1;
    b.exhausted = 1'b1;
    beat_q.push_back(b);
  endfunction

  function automatic void push_choice();
    combo_beat_t b;
    for (int k = 0; k < int'(pick_q); k++) begin
      b.element   = 6'(choice[k]);
      b.position  = 4'(k);
      b.last      = (k == int'(pick_q) - 1);
      b.exhausted = 1'b0;
      beat_q.push_back(b);
    end
  endfunction

  // next combination in lexicographic order, or the exhausted marker
  function automatic void predict_combination(input logic restart);
    int n;
    int m;
    int k;
    n = set_size_q;
    m = pick_q;
    if (m == 0 || n == 0 || m > n || n > SET_LIMIT || m > PICK_LIMIT) begin
      push_exhausted();
      return;
    end
    if (restart || !started) begin
      for (int i = 0; i < m; i++) choice[i] = i;
      started  = 1'b1;
      finished = 1'b0;
      push_choice();
      return;
    end
    if (finished) begin
      push_exhausted();
      return;
    end
    // rightmost position still below its ceiling
    k = m;
    while (k > 0 && choice[k-1] >= (k - 1) + (n - m)) k--;
    if (k == 0) begin
      finished = 1'b1;
      push_exhausted();
      return;
    end
    k--;
    choice[k]++;
    for (int i = k + 1; i < m; i++) choice[i] = choice[i-1] + 1;
    push_choice();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    combo_beat_t want;
    combo_beat_t got;
    if (!rst_ni) begin
      beat_q.delete();
      set_size_q = '0;
      pick_q     = '0;
      for (int i = 0; i < PICK_LIMIT; i++) choice[i] = 0;
      started  = 1'b0;
      finished = 1'b0;
      fails    = 0;
      pending  = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.element   = m_axis_tdata_o[5:0];
        got.position  = m_axis_tdata_o[9:6];
        got.last      = m_axis_tlast_o;
        got.exhausted = m_axis_tuser_o;
        if (beat_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: element %0d position %0d last %0b exhausted %0b",
                     got.element, got.position, got.last, got.exhausted);
          fails++;
        end else begin
          want = beat_q.pop_front();
          if (want.element !== got.element || want.position !== got.position ||
              want.last !== got.last || want.exhausted !== got.exhausted) begin
            if (fails < 10)
              $display({"result mismatch: expected element %0d position %0d last %0b ",
                        "exhausted %0b, got element %0d position %0d last %0b exhausted %0b"},
                       want.element, want.position, want.last, want.exhausted,
                       got.element, got.position, got.last, got.exhausted);
            fails++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) predict_combination(s_axis_tdata_i[0]);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SET_SIZE: begin
            set_size_q = cfg_data_i;
            started    = 1'b0;
            finished   = 1'b0;
          end
          REG_PICK_COUNT: begin
            pick_q   = cfg_data_i[4:0];
            started  = 1'b0;
            finished = 1'b0;
          end
          default: ;
        endcase
      end
      pending = beat_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top of the combination enumerator: stimulus, back pressure and verdict
//
// the stimulus walks the block through many (set size, pick count) settings:
// a short directed pass over the corners (invalid settings of every kind,
// single combinations, the widest row, running past the last combination,
// restarts, writes to unused register indexes), then random phases that mostly
// use small sets so that the enumeration carries deep and runs out, plus one
// full walk over 64 elements with a single pick so every element value shows up
// the checker beside the block predicts and compares every result
module tb_top;
  import ce_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int SINK_HOLD    = 300;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;   // [0] restart, rest zero
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [15:0]          m_axis_tdata_o;         // [5:0] element, [9:6] position, zero fill
  logic                 m_axis_tlast_o;
  logic                 m_axis_tuser_o;         // [0] exhausted
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [6:0]           cfg_data_i      = '0;

  int fail_count;
  int pending;
  int sent_total    = 0;
  int src_run       = 0;   // requests left in a stretch without sender gaps
  int sink_run      = 0;   // results left in a stretch without receiver stalls
  bit sink_hold_req = 1'b0;

  combination_enumerator DUT (.*);

  ce_checker u_checker (
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .*
  );

  always #1 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // gap before the next transfer on one side, with occasional stretches of none
  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(8, 40);
    return $urandom_range(0, 12);
  endfunction

  // result side: random stalls, plus one long hold when asked for
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        gap = SINK_HOLD;
      end else begin
        gap = pick_gap(sink_run);
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // one request; valid stays up afterwards so back-to-back requests keep it high
  task automatic send_request(input logic restart, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_total++;
  endtask

  // stop offering requests and let every expected result drain
  task automatic wait_quiet();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // new setting, only once the block is idle; pick count carries random upper bits
  task automatic configure(input logic [6:0] n, input logic [4:0] m);
    wait_quiet();
    if ($urandom_range(0, 6) == 0)
      write_register(CFG_IDX_W'($urandom_range(REG_PICK_COUNT + 1, 2**CFG_IDX_W - 1)),
                     7'($urandom));
    write_register(REG_SET_SIZE, n);
    write_register(REG_PICK_COUNT, {2'($urandom_range(0, 3)), m});
  endtask

  task automatic issue(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) wait_quiet();   // sender waits for all results
      send_request($urandom_range(0, 99) < restart_pct, pick_gap(src_run));
    end
  endtask

  initial begin : stimulus
    int n;
    int m;
    int count;
    int kind;
    int phase;
    int random_base;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset: zero size and zero pick are invalid
    issue(1, 0);
    // six combinations, then run past the end twice, then restart
    configure(7'd4, 5'd2);
    issue(8, 0);
    send_request(1'b1, pick_gap(src_run));
    issue(1, 0);
    // a write to an unused index must not disturb the enumeration
    configure(7'd4, 5'd1);
    issue(1, 0);
    wait_quiet();
    write_register(REG_PICK_COUNT + 4'd8, 7'h7f);
    issue(1, 0);
    // invalid settings: pick above size, size above limit, pick above limit, zero size
    configure(7'd5, 5'd6);
    send_request(1'b1, pick_gap(src_run));
    configure(7'd100, 5'd4);
    issue(1, 0);
    configure(7'd20, 5'd20);
    issue(1, 0);
    configure(7'd0, 5'd3);
    issue(1, 0);
    // widest row, restart on a fresh setting
    configure(7'd64, 5'd16);
    issue(1, 0);
    send_request(1'b1, pick_gap(src_run));
    issue(1, 0);
    // single combination cases
    configure(7'd16, 5'd16);
    issue(3, 0);
    configure(7'd1, 5'd1);
    issue(2, 0);

    // receiver holds off while requests keep coming, so the block stalls its input
    configure(7'd64, 5'd16);
    sink_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_request(1'b0, 0);
    wait_quiet();

    random_base = sent_total;
    phase = 0;
    while (sent_total - random_base < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (phase == 0) begin
        // full walk over every element value and past the end
        n = 64;
        m = 1;
        count = 66;
      end else if (kind < 65) begin
        n = $urandom_range(1, 9);
        m = $urandom_range(1, n);
        count = $urandom_range(3, 40);
      end else if (kind < 78) begin
        n = $urandom_range(17, 64);
        m = $urandom_range(1, 16);
        count = $urandom_range(4, 24);
      end else if (kind < 88) begin
        m = $urandom_range(10, 16);
        n = m + $urandom_range(0, 2);
        count = $urandom_range(4, 60);
      end else begin
        n = $urandom_range(0, 127);
        m = $urandom_range(0, 31);
        if (m >= 1 && m <= 16 && n >= m && n <= 64) m = 0;
        count = $urandom_range(1, 4);
      end
      configure(7'(n), 5'(m));
      issue(count, 8);
      phase++;
    end

    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
